FILE: design/jsv_pkg.sv
// ----------------------------------------------------------------------------
// jsv_pkg
// Types and constants shared by the JSON syntax validator: the request and
// response payloads, scanner mode codes, character codes and literal text.
// ----------------------------------------------------------------------------
package jsv_pkg;

   localparam int DATA_W        = 8;
   localparam int DEPTH_LIMIT_W = 7;
   localparam int OPEN_LEVELS_W = 7;
   localparam int VERDICT_W     = 2;
   localparam int MODE_W        = 5;
   localparam int SUB_W         = 3;
   localparam int KIND_W        = 2;

   localparam logic [DEPTH_LIMIT_W-1:0] DEPTH_LIMIT_RESET = 7'd64;
   localparam logic [OPEN_LEVELS_W-1:0] OPEN_LEVELS_MAX   = 7'd127;

   // Verdict codes.
   localparam logic [VERDICT_W-1:0] VERDICT_PENDING = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_VALID   = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_ERROR   = 2'd2;

   // Scanner modes.
   localparam logic [MODE_W-1:0] MODE_START     = 5'd0;
   localparam logic [MODE_W-1:0] MODE_ARR_FIRST = 5'd1;
   localparam logic [MODE_W-1:0] MODE_OBJ_FIRST = 5'd2;
   localparam logic [MODE_W-1:0] MODE_VALUE     = 5'd3;
   localparam logic [MODE_W-1:0] MODE_KEY       = 5'd4;
   localparam logic [MODE_W-1:0] MODE_COLON     = 5'd5;
   localparam logic [MODE_W-1:0] MODE_AFTER     = 5'd6;
   localparam logic [MODE_W-1:0] MODE_DONE      = 5'd7;
   localparam logic [MODE_W-1:0] MODE_STR       = 5'd8;
   localparam logic [MODE_W-1:0] MODE_ESC       = 5'd9;
   localparam logic [MODE_W-1:0] MODE_HEX       = 5'd10;
   localparam logic [MODE_W-1:0] MODE_LIT       = 5'd11;
   localparam logic [MODE_W-1:0] MODE_NSIGN     = 5'd12;
   localparam logic [MODE_W-1:0] MODE_NZERO     = 5'd13;
   localparam logic [MODE_W-1:0] MODE_NINT      = 5'd14;
   localparam logic [MODE_W-1:0] MODE_NDOT      = 5'd15;
   localparam logic [MODE_W-1:0] MODE_NFRAC     = 5'd16;
   localparam logic [MODE_W-1:0] MODE_NE        = 5'd17;
   localparam logic [MODE_W-1:0] MODE_NESIGN    = 5'd18;
   localparam logic [MODE_W-1:0] MODE_NEXP      = 5'd19;

   // Literal selectors.
   localparam logic [KIND_W-1:0] LIT_TRUE  = 2'd0;
   localparam logic [KIND_W-1:0] LIT_FALSE = 2'd1;
   localparam logic [KIND_W-1:0] LIT_NULL  = 2'd2;

   // Character codes.
   localparam logic [DATA_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [DATA_W-1:0] CH_TAB    = 8'h09;
   localparam logic [DATA_W-1:0] CH_CR     = 8'h0D;
   localparam logic [DATA_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [DATA_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [DATA_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [DATA_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [DATA_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [DATA_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [DATA_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [DATA_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [DATA_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [DATA_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [DATA_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [DATA_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [DATA_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [DATA_W-1:0] CH_NINE   = 8'h39;
   localparam logic [DATA_W-1:0] CH_UP_A   = 8'h41;
   localparam logic [DATA_W-1:0] CH_UP_E   = 8'h45;
   localparam logic [DATA_W-1:0] CH_UP_F   = 8'h46;
   localparam logic [DATA_W-1:0] CH_LO_A   = 8'h61;
   localparam logic [DATA_W-1:0] CH_LO_B   = 8'h62;
   localparam logic [DATA_W-1:0] CH_LO_E   = 8'h65;
   localparam logic [DATA_W-1:0] CH_LO_F   = 8'h66;
   localparam logic [DATA_W-1:0] CH_LO_N   = 8'h6E;
   localparam logic [DATA_W-1:0] CH_LO_R   = 8'h72;
   localparam logic [DATA_W-1:0] CH_LO_T   = 8'h74;
   localparam logic [DATA_W-1:0] CH_LO_U   = 8'h75;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              is_last;
   } req_payload_type;

   typedef struct packed {
      logic [VERDICT_W-1:0]     verdict;
      logic [OPEN_LEVELS_W-1:0] open_levels;
   } rsp_payload_type;

   // Length of the selected literal.
   function automatic logic [SUB_W-1:0] lit_len(logic [KIND_W-1:0] k);
      logic [SUB_W-1:0] len;
      unique case (k)
         LIT_FALSE: begin
            len = 3'd5;
         end
         default: begin
            len = 3'd4;
         end
      endcase
      return len;
   endfunction

   // Character at position idx of the selected literal.
   function automatic logic [DATA_W-1:0] lit_char(logic [KIND_W-1:0] k,
                                                  logic [SUB_W-1:0] idx);
      logic [DATA_W-1:0] ch;
      ch = '0;
      unique case (k)
         LIT_TRUE: begin
            unique case (idx)
               3'd0:    ch = "t";
               3'd1:    ch = "r";
               3'd2:    ch = "u";
               3'd3:    ch = "e";
               default: ch = '0;
            endcase
         end
         LIT_FALSE: begin
            unique case (idx)
               3'd0:    ch = "f";
               3'd1:    ch = "a";
               3'd2:    ch = "l";
               3'd3:    ch = "s";
               3'd4:    ch = "e";
               default: ch = '0;
            endcase
         end
         default: begin
            unique case (idx)
               3'd0:    ch = "n";
               3'd1:    ch = "u";
               3'd2:    ch = "l";
               3'd3:    ch = "l";
               default: ch = '0;
            endcase
         end
      endcase
      return ch;
   endfunction

endpackage

FILE: design/json_syntax_validator_unit.sv
// ----------------------------------------------------------------------------
// json_syntax_validator_unit
// Streaming JSON syntax checker that takes one document byte per request and
// returns one verdict per byte.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_ready   data_byte, is_last
//   rsp_     out        rsp_valid/rsp_ready   verdict, open_levels
//   csr_     in         csr_wr_en (no wait)   depth_limit
//
// A request is loaded into the input register at the edge that accepts it.
// The scanner logic works on the input register, and its result is loaded
// into the response register once that register is free or being emptied,
// so a held response stalls the input register. The scanner state and the
// container stack are updated in the same edge that loads the response, so
// one request per cycle is sustained while rsp_ready is held high.
// Reset is synchronous and active high; it clears the scanner and sets the
// depth limit to 64. The container stack memory is not cleared.
// When rsp_ready is low the response register holds, the input register
// fills, and req_ready drops only once both are occupied.
// ----------------------------------------------------------------------------
module json_syntax_validator_unit
   import jsv_pkg::*;
#(
   parameter int MAX_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_payload_type          req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_payload_type          rsp_data,
   input  logic                     csr_wr_en,
   input  logic [DEPTH_LIMIT_W-1:0] csr_wr_data
);

   // The nesting level runs from zero to MAX_DEPTH + 1, the stack holds one
   // entry for each level from zero to MAX_DEPTH.
   localparam int LEVEL_W = $clog2(MAX_DEPTH + 2);
   localparam int ADDR_W  = $clog2(MAX_DEPTH + 1);
   localparam int CMP_W   = (LEVEL_W > DEPTH_LIMIT_W) ? LEVEL_W : DEPTH_LIMIT_W;
   localparam int STACK_D = MAX_DEPTH + 1;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [LEVEL_W-1:0] level;
      logic [SUB_W-1:0]   sub;
      logic [KIND_W-1:0]  kind;
      logic               err;
   } scan_type;

   // One pass of the scanner over a byte, plus the stack write it asks for.
   typedef struct packed {
      scan_type st;
      logic     again;
      logic     push;
      logic     push_obj;
   } step_type;

   localparam scan_type SCAN_CLEAR = '{
      mode:  MODE_START,
      level: '0,
      sub:   '0,
      kind:  '0,
      err:   1'b0
   };

   // -------------------------------------------------------------------------
   // Character classes and scanner helpers
   // -------------------------------------------------------------------------
   function automatic logic is_ws(logic [DATA_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(logic [DATA_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_hex(logic [DATA_W-1:0] c);
      return is_digit(c) || ((c >= CH_UP_A) && (c <= CH_UP_F)) ||
             ((c >= CH_LO_A) && (c <= CH_LO_F));
   endfunction

   // Where the scanner goes once a complete value has been seen.
   function automatic logic [MODE_W-1:0] done_mode(logic [LEVEL_W-1:0] lvl);
      return (lvl == '0) ? MODE_DONE : MODE_AFTER;
   endfunction

   function automatic step_type do_push(step_type r, logic obj);
      step_type q;
      q = r;
      if (CMP_W'(r.st.level) > CMP_W'(MAX_DEPTH)) begin
         q.st.err = 1'b1;
      end else begin
         q.push     = 1'b1;
         q.push_obj = obj;
         q.st.level = r.st.level + LEVEL_W'(1);
         q.st.mode  = obj ? MODE_OBJ_FIRST : MODE_ARR_FIRST;
      end
      return q;
   endfunction

   function automatic step_type do_pop(step_type r);
      step_type q;
      q = r;
      if (r.st.level != '0) begin
         q.st.level = r.st.level - LEVEL_W'(1);
      end
      q.st.mode = done_mode(q.st.level);
      return q;
   endfunction

   function automatic step_type value_start(step_type r, logic [DATA_W-1:0] c,
                                            logic over_limit);
      step_type q;
      q = r;
      if (over_limit) begin
         q.st.err = 1'b1;
      end else if (c == CH_QUOTE) begin
         q.st.kind = LIT_TRUE;
         q.st.mode = MODE_STR;
      end else if (c == CH_LBRACE) begin
         q = do_push(r, 1'b1);
      end else if (c == CH_LBRACK) begin
         q = do_push(r, 1'b0);
      end else if ((c == CH_LO_T) || (c == CH_LO_F) || (c == CH_LO_N)) begin
         q.st.kind = (c == CH_LO_T) ? LIT_TRUE : ((c == CH_LO_F) ? LIT_FALSE : LIT_NULL);
         q.st.sub  = SUB_W'(1);
         q.st.mode = MODE_LIT;
      end else if (c == CH_MINUS) begin
         q.st.mode = MODE_NSIGN;
      end else if (c == CH_ZERO) begin
         q.st.mode = MODE_NZERO;
      end else if (is_digit(c)) begin
         q.st.mode = MODE_NINT;
      end else begin
         q.st.err = 1'b1;
      end
      return q;
   endfunction

   // One scanner pass. A byte that ends a number sets again, and the byte is
   // then scanned a second time in the mode that follows the number.
   function automatic step_type scan_step(scan_type s, logic [DATA_W-1:0] c,
                                          logic top_obj, logic over_limit);
      step_type          r;
      logic [SUB_W:0]    sub_inc;
      logic [KIND_W-1:0] k;
      logic [SUB_W-1:0]  len;
      logic              is_e;
      r.st       = s;
      r.again    = 1'b0;
      r.push     = 1'b0;
      r.push_obj = 1'b0;
      sub_inc    = {1'b0, s.sub} + (SUB_W + 1)'(1);
      k          = (s.kind > LIT_NULL) ? LIT_NULL : s.kind;
      len        = lit_len(k);
      is_e       = (c == CH_LO_E) || (c == CH_UP_E);
      unique case (s.mode) inside
         MODE_START, MODE_VALUE: begin
            if (!is_ws(c)) begin
               r = value_start(r, c, over_limit);
            end
         end
         MODE_ARR_FIRST: begin
            if (!is_ws(c)) begin
               if (c == CH_RBRACK) begin
                  r = do_pop(r);
               end else begin
                  r = value_start(r, c, over_limit);
               end
            end
         end
         MODE_OBJ_FIRST, MODE_KEY: begin
            if (!is_ws(c)) begin
               if ((s.mode == MODE_OBJ_FIRST) && (c == CH_RBRACE)) begin
                  r = do_pop(r);
               end else if (c == CH_QUOTE) begin
                  r.st.kind = LIT_FALSE;
                  r.st.mode = MODE_STR;
               end else begin
                  r.st.err = 1'b1;
               end
            end
         end
         MODE_COLON: begin
            if (!is_ws(c)) begin
               if (c == CH_COLON) begin
                  r.st.mode = MODE_VALUE;
               end else begin
                  r.st.err = 1'b1;
               end
            end
         end
         MODE_AFTER: begin
            if (!is_ws(c)) begin
               if (c == CH_COMMA) begin
                  r.st.mode = top_obj ? MODE_KEY : MODE_VALUE;
               end else if (c == (top_obj ? CH_RBRACE : CH_RBRACK)) begin
                  r = do_pop(r);
               end else begin
                  r.st.err = 1'b1;
               end
            end
         end
         MODE_DONE: begin
            if (!is_ws(c)) begin
               r.st.err = 1'b1;
            end
         end
         MODE_STR: begin
            if (c == CH_QUOTE) begin
               // Bit 0 of the kind marks a string that is an object key.
               r.st.mode = s.kind[0] ? MODE_COLON : done_mode(s.level);
               r.st.kind = '0;
            end else if (c < CH_SPACE) begin
               r.st.err = 1'b1;
            end else if (c == CH_BSLASH) begin
               r.st.mode = MODE_ESC;
            end
         end
         MODE_ESC: begin
            if (c == CH_LO_U) begin
               r.st.sub  = '0;
               r.st.mode = MODE_HEX;
            end else if ((c == CH_QUOTE) || (c == CH_BSLASH) || (c == CH_SLASH) ||
                         (c == CH_LO_B) || (c == CH_LO_F) || (c == CH_LO_N) ||
                         (c == CH_LO_R) || (c == CH_LO_T)) begin
               r.st.mode = MODE_STR;
            end else begin
               r.st.err = 1'b1;
            end
         end
         MODE_HEX: begin
            if (!is_hex(c)) begin
               r.st.err = 1'b1;
            end else if (sub_inc >= (SUB_W + 1)'(4)) begin
               r.st.sub  = '0;
               r.st.mode = MODE_STR;
            end else begin
               r.st.sub = sub_inc[SUB_W-1:0];
            end
         end
         MODE_LIT: begin
            if ((s.sub >= len) || (c != lit_char(k, s.sub))) begin
               r.st.err = 1'b1;
            end else if (sub_inc == {1'b0, len}) begin
               r.st.sub  = '0;
               r.st.kind = '0;
               r.st.mode = done_mode(s.level);
            end else begin
               r.st.sub = sub_inc[SUB_W-1:0];
            end
         end
         MODE_NSIGN: begin
            if (c == CH_ZERO) begin
               r.st.mode = MODE_NZERO;
            end else if (is_digit(c)) begin
               r.st.mode = MODE_NINT;
            end else begin
               r.st.err = 1'b1;
            end
         end
         MODE_NZERO, MODE_NINT, MODE_NFRAC: begin
            if ((s.mode != MODE_NZERO) && is_digit(c)) begin
               r.st.mode = s.mode;
            end else if ((c == CH_DOT) && (s.mode != MODE_NFRAC)) begin
               r.st.mode = MODE_NDOT;
            end else if (is_e) begin
               r.st.mode = MODE_NE;
            end else begin
               r.st.mode = done_mode(s.level);
               r.again   = 1'b1;
            end
         end
         MODE_NDOT: begin
            if (is_digit(c)) begin
               r.st.mode = MODE_NFRAC;
            end else begin
               r.st.err = 1'b1;
            end
         end
         MODE_NE: begin
            if ((c == CH_PLUS) || (c == CH_MINUS)) begin
               r.st.mode = MODE_NESIGN;
            end else if (is_digit(c)) begin
               r.st.mode = MODE_NEXP;
            end else begin
               r.st.err = 1'b1;
            end
         end
         MODE_NESIGN: begin
            if (is_digit(c)) begin
               r.st.mode = MODE_NEXP;
            end else begin
               r.st.err = 1'b1;
            end
         end
         MODE_NEXP: begin
            if (!is_digit(c)) begin
               r.st.mode = done_mode(s.level);
               r.again   = 1'b1;
            end
         end
         default: begin
            r.st.err = 1'b1;
         end
      endcase
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   logic [DEPTH_LIMIT_W-1:0] depth_limit_ff;
   logic                     in_valid_ff, in_valid_in;
   req_payload_type          in_data_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_data_ff;
   scan_type                 scan_ff, scan_in;
   logic                     push_ff;
   logic                     push_obj_ff;
   logic                     stack_rd_ff;
   logic                     stack_mem [STACK_D];

   // -------------------------------------------------------------------------
   // Handshake
   // -------------------------------------------------------------------------
   logic advance;
   logic fire;
   logic req_fire;

   // The scanner stage moves whenever the response register is free or is
   // being emptied in this cycle.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   // -------------------------------------------------------------------------
   // Scanner
   // -------------------------------------------------------------------------
   logic [DEPTH_LIMIT_W-1:0] eff_limit;
   logic                     over_limit;
   logic                     top_obj;
   step_type                 pass1;
   step_type                 pass2;
   step_type                 pass;
   scan_type                 fin;
   rsp_payload_type          rsp_next;
   logic [CMP_W-1:0]         level_ext;
   logic [LEVEL_W-1:0]       rd_level;
   logic [ADDR_W-1:0]        rd_addr;

   // A limit above the stack depth behaves as the stack depth.
   assign eff_limit = (CMP_W'(depth_limit_ff) > CMP_W'(MAX_DEPTH)) ?
                      DEPTH_LIMIT_W'(MAX_DEPTH) : depth_limit_ff;
   assign over_limit = CMP_W'(scan_ff.level) > CMP_W'(eff_limit);

   // The top of the stack comes from the registered memory read, except in the
   // cycle right after a push, when the memory read still shows the old entry.
   assign top_obj = (scan_ff.level == '0) ? 1'b0 :
                    (push_ff ? push_obj_ff : stack_rd_ff);

   always_comb begin
      pass1 = scan_step(scan_ff, in_data_ff.data_byte, top_obj, over_limit);
      pass2 = scan_step(pass1.st, in_data_ff.data_byte, top_obj, over_limit);
      if (scan_ff.err) begin
         // After an error the bytes are ignored until the last one.
         pass.st       = scan_ff;
         pass.again    = 1'b0;
         pass.push     = 1'b0;
         pass.push_obj = 1'b0;
      end else if (pass1.again && !pass1.st.err) begin
         pass = pass2;
      end else begin
         pass = pass1;
      end

      fin = pass.st;
      if (in_data_ff.is_last && !fin.err) begin
         // A complete number may close the document.
         if ((fin.mode == MODE_NZERO) || (fin.mode == MODE_NINT) ||
             (fin.mode == MODE_NFRAC) || (fin.mode == MODE_NEXP)) begin
            fin.mode = done_mode(fin.level);
         end
         if (fin.mode != MODE_DONE) begin
            fin.err = 1'b1;
         end
      end

      level_ext = CMP_W'(fin.level);
      rsp_next.open_levels = (level_ext > CMP_W'(OPEN_LEVELS_MAX)) ?
                             OPEN_LEVELS_MAX : level_ext[OPEN_LEVELS_W-1:0];
      if (fin.err) begin
         rsp_next.verdict = VERDICT_ERROR;
      end else if (in_data_ff.is_last) begin
         rsp_next.verdict = VERDICT_VALID;
      end else begin
         rsp_next.verdict = VERDICT_PENDING;
      end

      scan_in = scan_ff;
      if (fire) begin
         scan_in = in_data_ff.is_last ? SCAN_CLEAR : fin;
      end

      // Read the entry that will be on top after this edge.
      rd_level = (scan_in.level == '0) ? '0 : (scan_in.level - LEVEL_W'(1));
      rd_addr  = rd_level[ADDR_W-1:0];
   end

   // -------------------------------------------------------------------------
   // Sequential logic
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_limit_ff <= DEPTH_LIMIT_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         scan_ff        <= SCAN_CLEAR;
         push_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            depth_limit_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         push_ff      <= fire && pass.push;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_next;
         push_obj_ff <= pass.push_obj;
      end
   end

   // Container stack: one write port at the current level, one registered read.
   always_ff @(posedge clock) begin
      if (fire && pass.push) begin
         stack_mem[scan_ff.level[ADDR_W-1:0]] <= pass.push_obj;
      end
      stack_rd_ff <= stack_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
